[hw/rtl/flp_pkg.sv]
package flp_pkg;

    // Fixed-point format and history geometry.
    localparam int FRAC_BITS  = 16;
    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // Field and internal widths.
    localparam int MU_W     = 23;
    localparam int FOOT_W   = 8;
    localparam int ENERGY_W = 24;
    localparam int LOG_W    = 40;
    localparam int POS_W    = 20;
    localparam int TERM_W   = 44;
    localparam int ACC_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;

    // Footprint counter holds the largest size plus one.
    localparam int SIZE_W = ((HIST_AW > FOOT_W) ? HIST_AW : FOOT_W) + 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Log-sum-exp correction table.
    localparam int LSE_N     = 256;
    localparam int LSE_IW    = 8;
    localparam int LSE_W     = FRAC_BITS + 1;
    localparam int LSE_SHIFT = FRAC_BITS - 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MU  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd2;

    // Reset values of the configuration registers.
    localparam logic signed [MU_W-1:0] MU_RESET  = -23'sd1638400;
    localparam logic [FOOT_W-1:0]      MIN_RESET = 8'd91;
    localparam logic [FOOT_W-1:0]      MAX_RESET = 8'd147;

    typedef logic [LSE_W-1:0] t_lse_tab [LSE_N];

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Builds ln(1+exp(-(2k+1)/32)) in Q30 with series arithmetic, rounded
    // to the working fraction width. Evaluated once at elaboration.
    function automatic t_lse_tab build_lse_tab();
        t_lse_tab tab;
        longint unsigned one;
        longint unsigned term;
        longint unsigned c;
        longint unsigned c2;
        longint unsigned e;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned pw;
        longint unsigned sum;
        longint unsigned f;
        one  = 64'd1 << 30;
        term = one;
        c    = one;
        for (int n = 1; n <= 8; n++) begin
            term = div_u64(term, 64'd32 * longint'(n));
            if ((n & 1) == 1) begin
                c = c - term;
            end else begin
                c = c + term;
            end
        end
        c2 = (c * c + (64'd1 << 29)) >> 30;
        e  = c;
        for (int k = 0; k < LSE_N; k++) begin
            z   = div_u64(e << 30, 64'd2 * one + e);
            z2  = (z * z) >> 30;
            pw  = z;
            sum = 0;
            for (int j = 0; j < 12; j++) begin
                sum = sum + div_u64(pw, 64'd2 * longint'(j) + 64'd1);
                pw  = (pw * z2) >> 30;
            end
            f = 64'd2 * sum;
            tab[k] = LSE_W'((f + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
            e = (e * c2 + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam t_lse_tab LSE_TAB = build_lse_tab();

endpackage

[hw/rtl/flp_ram.sv]
module flp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/forward_log_partition_dp_unit.sv]
// Forward log partition function of a footprint lattice, one base per word.
// Input channel: i_valid / o_stall carry i_base_energy (signed Q7.16) and
// i_first_base, which starts a new sequence at that base. Output channel:
// o_valid / i_stall carry o_log_partition (signed Q23.16), o_base_index and
// the sticky o_saturated flag, one output word per input word.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the log binding factor, 1 the minimum and 2 the maximum
// footprint. Writes are taken in every cycle and should happen while idle.
// After acceptance an item passes the states S_PREV, S_INIT, S_RUN and
// S_FIN in that order; S_RUN issues the N footprint sizes that fit (at most
// 255, possibly none). Each size passes through the shared log-add unit,
// fed by one read per cycle of the history RAM; o_stall stays high from
// acceptance until the word reaches the output register, so no new word is
// taken while an item is in flight.
// When the receiver stalls, the finished word waits in the output register
// and the next item is taken; its result waits until that register frees.
// Reset (synchronous, active low) restores the register defaults and starts
// a new sequence at base 0. The history RAM needs no clearing.
module forward_log_partition_dp_unit
    import flp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ENERGY_W-1:0]    i_base_energy,
    input  logic                          i_first_base,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [LOG_W-1:0]       o_log_partition,
    output logic [POS_W-1:0]              o_base_index,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREV = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic signed [ACC_W-1:0] LOG_MAX = ACC_W'({1'b0, {(LOG_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] LOG_MIN = -(ACC_W'(1) <<< (LOG_W-1));

    logic [2:0]                 r_state;
    logic signed [MU_W-1:0]     r_mu;
    logic [FOOT_W-1:0]          r_min;
    logic [FOOT_W-1:0]          r_max;
    logic [LOG_W-1:0]           r_prefix;
    logic [POS_W-1:0]           r_pos;
    logic [POS_W-1:0]           r_idx;
    logic [HIST_AW-1:0]         r_slot;
    logic                       r_sat;
    logic signed [ACC_W-1:0]    r_acc;
    logic [SIZE_W-1:0]          r_s;
    logic [SIZE_W-1:0]          r_hi;
    logic                       r_v1;
    logic                       r_first1;
    logic                       r_v2;
    logic signed [TERM_W-1:0]   r_term;
    logic                       r_out_v;
    logic signed [LOG_W-1:0]    r_out_log;
    logic [POS_W-1:0]           r_out_idx;
    logic                       r_out_sat;

    logic                       accept;
    logic                       issue;
    logic                       fin_go;
    logic [HIST_AW-1:0]         raddr;
    logic [2*LOG_W-1:0]         rdata;
    logic [2*LOG_W-1:0]         wdata;
    logic signed [LOG_W-1:0]    rd_log;
    logic [LOG_W-1:0]           rd_prefix;
    logic [POS_W:0]             idx_p1;
    logic [SIZE_W-1:0]          hi_cap;
    logic signed [LOG_W-1:0]    lprev;
    logic [LOG_W-1:0]           pprev;
    logic signed [LOG_W-1:0]    ew;
    logic signed [TERM_W-1:0]   term_val;
    logic signed [ACC_W-1:0]    term_ext;
    logic signed [ACC_W-1:0]    lse_hi;
    logic [ACC_W-1:0]           lse_d;
    logic [ACC_W-1:0]           lse_k;
    logic signed [ACC_W-1:0]    lse_sum;
    logic signed [ACC_W-1:0]    clamped;
    logic                       clip;
    logic [LOG_W-1:0]           base_prefix;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu  <= MU_RESET;
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MU:  r_mu  <= i_cfg_data[MU_W-1:0];
                CFG_MIN: r_min <= i_cfg_data[FOOT_W-1:0];
                CFG_MAX: r_max <= i_cfg_data[FOOT_W-1:0];
                default: ;
            endcase
        end
    end

    // History RAM: log value in the upper half, energy prefix in the lower.
    assign raddr = (r_state == S_PREV) ? (r_slot - HIST_AW'(1))
                                       : (r_slot - r_s[HIST_AW-1:0]);
    assign wdata = {clamped[LOG_W-1:0], r_prefix};

    flp_ram #(
        .WIDTH (2*LOG_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (fin_go),
        .i_waddr (r_slot),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_log    = rdata[2*LOG_W-1:LOG_W];
    assign rd_prefix = rdata[LOG_W-1:0];

    // Largest size that fits: the register, the history depth and the position.
    assign idx_p1 = {1'b0, r_idx} + (POS_W+1)'(1);
    always_comb begin
        hi_cap = SIZE_W'(r_max);
        if (hi_cap > SIZE_W'(HIST_DEPTH)) begin
            hi_cap = SIZE_W'(HIST_DEPTH);
        end
        if ((POS_W+1)'(hi_cap) > idx_p1) begin
            hi_cap = idx_p1[SIZE_W-1:0];
        end
    end

    assign issue = (r_state == S_RUN) && (r_s <= r_hi);

    // Term of one footprint: mu minus window energy plus earlier log value.
    always_comb begin
        lprev    = r_first1 ? '0 : rd_log;
        pprev    = r_first1 ? '0 : rd_prefix;
        ew       = r_prefix - pprev;
        term_val = TERM_W'(r_mu) - TERM_W'(ew) + TERM_W'(lprev);
    end

    // Shared log-add unit: max plus table correction.
    always_comb begin
        term_ext = ACC_W'(r_term);
        if (r_acc > term_ext) begin
            lse_hi = r_acc;
            lse_d  = r_acc - term_ext;
        end else begin
            lse_hi = term_ext;
            lse_d  = term_ext - r_acc;
        end
        lse_k   = lse_d >> LSE_SHIFT;
        lse_sum = lse_hi;
        if (lse_k < ACC_W'(LSE_N)) begin
            lse_sum = lse_hi + ACC_W'(LSE_TAB[lse_k[LSE_IW-1:0]]);
        end
    end

    // Clamp to the output range.
    always_comb begin
        clamped = r_acc;
        clip    = 1'b0;
        if (r_acc > LOG_MAX) begin
            clamped = LOG_MAX;
            clip    = 1'b1;
        end else if (r_acc < LOG_MIN) begin
            clamped = LOG_MIN;
            clip    = 1'b1;
        end
    end

    assign fin_go      = (r_state == S_FIN) && (!r_out_v || !i_stall);
    assign base_prefix = i_first_base ? '0 : r_prefix;

    // Sequencer and per-item state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prefix <= '0;
            r_pos    <= '0;
            r_slot   <= '0;
            r_sat    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            // The output register fills on a finished item and empties when taken.
            if (fin_go) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prefix <= base_prefix + LOG_W'(i_base_energy);
                        if (i_first_base) begin
                            r_idx  <= '0;
                            r_pos  <= POS_W'(1);
                            r_slot <= '0;
                            r_sat  <= 1'b0;
                        end else begin
                            r_idx <= r_pos;
                            if (r_pos != POS_MAX) begin
                                r_pos <= r_pos + POS_W'(1);
                            end
                        end
                        r_state <= S_PREV;
                    end
                end
                S_PREV: begin
                    r_hi    <= hi_cap;
                    r_s     <= (r_min == '0) ? SIZE_W'(1) : SIZE_W'(r_min);
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (issue) begin
                        r_s <= r_s + SIZE_W'(1);
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_sat   <= r_sat | clip;
                        if (r_slot == HIST_AW'(HIST_DEPTH - 1)) begin
                            r_slot <= '0;
                        end else begin
                            r_slot <= r_slot + HIST_AW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        r_first1 <= ((POS_W+1)'(r_s) == idx_p1);
        r_term   <= term_val;
        // The accumulator starts from the previous base and then adds each term.
        if (r_state == S_INIT) begin
            r_acc <= (r_idx != '0) ? ACC_W'(rd_log) : '0;
        end else if (r_v2) begin
            r_acc <= lse_sum;
        end
        if (fin_go) begin
            r_out_log <= clamped[LOG_W-1:0];
            r_out_idx <= r_idx;
            r_out_sat <= r_sat | clip;
        end
    end

    assign o_valid         = r_out_v;
    assign o_log_partition = r_out_log;
    assign o_base_index    = r_out_idx;
    assign o_saturated     = r_out_sat;

endmodule
